// ===== rtl/core/ip_mask_filter_table_core_assert.svh =====
// Assertion macros shared by the table core.
`ifndef IP_MASK_FILTER_TABLE_CORE_ASSERT_SVH
`define IP_MASK_FILTER_TABLE_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define IPMF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ip_mask_filter_table_core: same-cycle check failed");

// The consequence must hold in the cycle after the antecedent.
`define IPMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ip_mask_filter_table_core: next-cycle check failed");

`endif

// ===== rtl/core/ipmf_pkg.sv =====
package ipmf_pkg;

    localparam int ADDR_W      = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [7:0]        OCTET_ON = 8'hff;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_CHECK
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CHECKED   = 3'd4
    } t_status;

    typedef struct packed {
        logic    load_req;
        logic    idx_inc;
        logic    ram_rd;
        logic    wr_new;
        logic    wr_at_count;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
        t_status out_status;
        logic    out_found;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic at_end;
        logic hit;
        logic full;
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] derive_mask(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            if (addr[k*8 +: 8] != 8'd0) begin
                m[k*8 +: 8] = OCTET_ON;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/ipmf_ram.sv =====
module ipmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ipmf_ctrl.sv =====
module ipmf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ipmf_pkg::t_sts i_sts,
    output ipmf_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    ipmf_pkg::t_status r_status, n_status;
    logic              r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ipmf_pkg::ST_ADDED;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_found  = r_found;
        o_cmd    = '0;
        o_cmd.out_status = r_status;
        o_cmd.out_found  = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_found        = 1'b0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.at_end) begin
                    n_state = S_DONE;
                    unique case (i_sts.op)
                        ipmf_pkg::OP_ADD: begin
                            if (i_sts.full) begin
                                n_status = ipmf_pkg::ST_FULL;
                            end else begin
                                o_cmd.wr_new      = 1'b1;
                                o_cmd.wr_at_count = 1'b1;
                                o_cmd.cnt_inc     = 1'b1;
                                n_status          = ipmf_pkg::ST_ADDED;
                            end
                        end
                        ipmf_pkg::OP_REMOVE: begin
                            n_status = ipmf_pkg::ST_NOT_FOUND;
                        end
                        default: begin
                            n_status = ipmf_pkg::ST_CHECKED;
                        end
                    endcase
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.hit) begin
                    unique case (i_sts.op)
                        ipmf_pkg::OP_ADD: begin
                            o_cmd.wr_new = 1'b1;
                            n_status     = ipmf_pkg::ST_ADDED;
                            n_state      = S_DONE;
                        end
                        ipmf_pkg::OP_REMOVE: begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_SH_RD;
                        end
                        default: begin
                            n_found  = 1'b1;
                            n_status = ipmf_pkg::ST_CHECKED;
                            n_state  = S_DONE;
                        end
                    endcase
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SH_RD: begin
                if (i_sts.at_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_status      = ipmf_pkg::ST_REMOVED;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SH_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/core/ipmf_dp.sv =====
module ipmf_dp #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ipmf_pkg::t_cmd                        i_cmd,
    output ipmf_pkg::t_sts                        o_sts,
    input  logic [ipmf_pkg::KIND_W-1:0]           i_kind,
    input  logic [ipmf_pkg::ADDR_W-1:0]           i_address,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [ipmf_pkg::STATUS_W-1:0]         o_status,
    output logic                                  o_blocked,
    output logic [ipmf_pkg::COUNT_OUT_W-1:0]      o_entry_count
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW = 2 * ipmf_pkg::ADDR_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    ipmf_pkg::t_op                       r_op;
    logic [ipmf_pkg::ADDR_W-1:0]         r_addr;
    logic [ipmf_pkg::ADDR_W-1:0]         r_mask;
    logic [CW-1:0]                       r_idx;
    logic [CW-1:0]                       r_count;
    logic                                r_ban;
    logic                                r_out_valid;
    logic [ipmf_pkg::STATUS_W-1:0]       r_out_status;
    logic                                r_out_blocked;
    logic [ipmf_pkg::COUNT_OUT_W-1:0]    r_out_count;

    logic [CW-1:0]                       w_idx_prev;
    logic [CW+ipmf_pkg::COUNT_OUT_W-1:0] w_count_ext;
    logic                                w_we;
    logic [AW-1:0]                       w_waddr;
    logic [EW-1:0]                       w_wdata;
    logic [EW-1:0]                       w_rdata;
    logic [ipmf_pkg::ADDR_W-1:0]         w_ent_mask;
    logic [ipmf_pkg::ADDR_W-1:0]         w_ent_cmp;
    logic                                w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_ban       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ban <= i_cfg_wdata;
            end
            if (i_cmd.load_req) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_addr <= i_address;
            r_mask <= ipmf_pkg::derive_mask(i_address);
            if (i_kind == ipmf_pkg::KIND_ADD) begin
                r_op <= ipmf_pkg::OP_ADD;
            end else if (i_kind == ipmf_pkg::KIND_REMOVE) begin
                r_op <= ipmf_pkg::OP_REMOVE;
            end else begin
                r_op <= ipmf_pkg::OP_CHECK;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status  <= i_cmd.out_status;
            r_out_blocked <= (r_op == ipmf_pkg::OP_CHECK) & ~(i_cmd.out_found ^ r_ban);
            r_out_count   <= w_count_ext[ipmf_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign w_idx_prev  = r_idx - 1'b1;
    assign w_count_ext = {{ipmf_pkg::COUNT_OUT_W{1'b0}}, r_count};

    assign w_we    = i_cmd.wr_new | i_cmd.wr_shift;
    assign w_wdata = i_cmd.wr_shift ? w_rdata : {r_mask, r_addr};

    always_comb begin
        if (i_cmd.wr_shift) begin
            w_waddr = w_idx_prev[AW-1:0];
        end else if (i_cmd.wr_at_count) begin
            w_waddr = r_count[AW-1:0];
        end else begin
            w_waddr = r_idx[AW-1:0];
        end
    end

    ipmf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_ent_mask = w_rdata[EW-1:ipmf_pkg::ADDR_W];
    assign w_ent_cmp  = w_rdata[ipmf_pkg::ADDR_W-1:0];

    always_comb begin
        unique case (r_op)
            ipmf_pkg::OP_ADD:    w_hit = (w_ent_cmp == ipmf_pkg::ALL_ONES);
            ipmf_pkg::OP_REMOVE: w_hit = (w_ent_mask == r_mask) && (w_ent_cmp == r_addr);
            default:             w_hit = ((r_addr & w_ent_mask) == w_ent_cmp);
        endcase
    end

    assign o_sts.op       = r_op;
    assign o_sts.at_end   = (r_idx == r_count);
    assign o_sts.hit      = w_hit;
    assign o_sts.full     = (r_count == MAX_CNT);
    assign o_sts.out_free = ~r_out_valid | ~i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_blocked     = r_out_blocked;
    assign o_entry_count = r_out_count;

endmodule

// ===== rtl/core/ip_mask_filter_table_core.sv =====
// A request scans the table one entry at a time through the registered RAM read port
// (states SCAN, then EVAL), until a hit or the last live entry, then loads the result
// register in DONE once the output is free. A remove also shifts the later entries down
// (states SH_RD, then SH_WR, per entry), and the next request is accepted when the block
// is back in IDLE, the cycle in which the result of the last one becomes valid.
// Reset empties the table at once (no clearing pass) and sets ban_mode to 1.
module ip_mask_filter_table_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ipmf_pkg::KIND_W-1:0]        i_kind,
    input  logic [ipmf_pkg::ADDR_W-1:0]        i_address,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ipmf_pkg::STATUS_W-1:0]      o_status,
    output logic                               o_blocked,
    output logic [ipmf_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata
);

    ipmf_pkg::t_cmd w_cmd;
    ipmf_pkg::t_sts w_sts;

    ipmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ipmf_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_blocked     (o_blocked),
        .o_entry_count (o_entry_count)
    );

`include "ip_mask_filter_table_core_assert.svh"

    // Only checks may report a refused address.
    `IPMF_ASSERT_IMPLIES(a_blocked_only_on_check, i_clk, i_rst_n, o_out_valid && (o_status != ipmf_pkg::ST_CHECKED), !o_blocked)
    // An accepted request keeps the block busy in the following cycle.
    `IPMF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // An append never grows a full table.
    `IPMF_ASSERT_IMPLIES(a_no_append_when_full, i_clk, i_rst_n, w_cmd.cnt_inc, !w_sts.full)

endmodule

// ===== verif/filter_table_checker.sv =====
`timescale 1ns / 100ps

module filter_table_checker
    import ipmf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [ADDR_W-1:0]      i_address,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [STATUS_W-1:0]    i_status,
    input  logic                   i_blocked,
    input  logic [COUNT_OUT_W-1:0] i_entry_count,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    output int                     o_pending,
    output int                     o_fail_count
);

    typedef struct packed {
        t_status                status;
        logic                   blocked;
        logic [COUNT_OUT_W-1:0] entry_count;
    } filter_reply_t;

    logic [ADDR_W-1:0] filter_mask    [MAX_ENTRIES];
    logic [ADDR_W-1:0] filter_compare [MAX_ENTRIES];
    int                filter_count;
    logic              ban_mode;
    filter_reply_t     predicted_replies [$];
    filter_reply_t     want;

    function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] m;
        for (int b = 0; b < 4; b++) begin
            m[8*b +: 8] = {8{|addr[8*b +: 8]}};
        end
        return m;
    endfunction

    function automatic filter_reply_t apply_filter_request(input logic [KIND_W-1:0] kind,
                                                           input logic [ADDR_W-1:0] addr);
        filter_reply_t     r;
        logic [ADDR_W-1:0] m;
        int                slot;
        logic              hit;
        m = octet_mask(addr);
        r.blocked = 1'b0;
        case (kind)
            KIND_ADD: begin
                slot = filter_count;
                for (int i = filter_count - 1; i >= 0; i--) begin
                    if (filter_compare[i] == ALL_ONES) begin
                        slot = i;
                    end
                end
                if (slot == filter_count && filter_count >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    filter_mask[slot]    = m;
                    filter_compare[slot] = addr;
                    if (slot == filter_count) begin
                        filter_count++;
                    end
                    r.status = ST_ADDED;
                end
            end
            KIND_REMOVE: begin
                slot = -1;
                for (int i = filter_count - 1; i >= 0; i--) begin
                    if (filter_mask[i] == m && filter_compare[i] == addr) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int j = slot; j < filter_count - 1; j++) begin
                        filter_mask[j]    = filter_mask[j+1];
                        filter_compare[j] = filter_compare[j+1];
                    end
                    filter_count--;
                    r.status = ST_REMOVED;
                end
            end
            default: begin
                hit = 1'b0;
                for (int i = 0; i < filter_count; i++) begin
                    if ((addr & filter_mask[i]) == filter_compare[i]) begin
                        hit = 1'b1;
                    end
                end
                r.blocked = hit ? ban_mode : ~ban_mode;
                r.status  = ST_CHECKED;
            end
        endcase
        r.entry_count = filter_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            filter_count = 0;
            ban_mode     = 1'b1;
            predicted_replies.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    $error("Unexpected transaction: status %0d, blocked %0d, entry_count %0d.",
                           i_status, i_blocked, i_entry_count);
                    o_fail_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("Mismatch on status: expected %0d, actual %0d.",
                               want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_blocked !== want.blocked) begin
                        $error("Mismatch on blocked: expected %0d, actual %0d.",
                               want.blocked, i_blocked);
                        o_fail_count++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("Mismatch on entry_count: expected %0d, actual %0d.",
                               want.entry_count, i_entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_replies.push_back(apply_filter_request(i_kind, i_address));
            end
            if (i_cfg_we) begin
                ban_mode = i_cfg_wdata;
            end
        end
        o_pending = predicted_replies.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import ipmf_pkg::*;

    localparam int              MAX_ENTRIES = 64;
    localparam real             CLK_PERIOD  = 8.0;
    localparam int              CYCLE_LIMIT = 3000000;
    localparam int              HOLD_CYCLES = 500;
    localparam int              POOL_DEPTH  = 80;
    localparam logic [KIND_W-1:0] KIND_CHECK = OP_CHECK;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [KIND_W-1:0]      kind;
    logic [ADDR_W-1:0]      address;
    logic                   out_valid;
    logic                   out_stall;
    logic [STATUS_W-1:0]    status;
    logic                   blocked;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   cfg_we;
    logic                   cfg_wdata;

    int                pending;
    int                fail_count;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    bit                hold_request = 1'b0;
    logic [ADDR_W-1:0] filter_pool [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    ip_mask_filter_table_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (kind),
        .i_address     (address),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_blocked     (blocked),
        .o_entry_count (entry_count),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    filter_table_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (kind),
        .i_address     (address),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_blocked     (blocked),
        .i_entry_count (entry_count),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver process owns out_stall, including the long hold-off.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        address  <= a;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_ban_mode(input logic value);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] random_filter_address();
        logic [ADDR_W-1:0] a;
        int                pick;
        if ($urandom_range(29) == 0) begin
            return ALL_ONES;
        end
        for (int b = 0; b < 4; b++) begin
            pick = $urandom_range(9);
            if (pick < 3) begin
                a[8*b +: 8] = 8'd0;
            end else if (pick < 6) begin
                a[8*b +: 8] = 8'($urandom_range(3, 1));
            end else if (pick == 6) begin
                a[8*b +: 8] = OCTET_ON;
            end else begin
                a[8*b +: 8] = 8'($urandom_range(255, 1));
            end
        end
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] pooled_filter();
        if (filter_pool.size() == 0) begin
            return random_filter_address();
        end
        return filter_pool[$urandom_range(filter_pool.size() - 1)];
    endfunction

    function automatic logic [ADDR_W-1:0] probe_address();
        logic [ADDR_W-1:0] a;
        int                pick;
        pick = $urandom_range(9);
        if (pick < 2) begin
            return $urandom();
        end
        a = pooled_filter();
        for (int b = 0; b < 4; b++) begin
            if (a[8*b +: 8] == 8'd0) begin
                a[8*b +: 8] = 8'($urandom_range(255));
            end
        end
        if (pick < 4) begin
            a[$urandom_range(ADDR_W - 1)] ^= 1'b1;
        end
        return a;
    endfunction

    task automatic run_phase(input logic ban, input int idle_pct, input int stall,
                             input int count, input int add_pct, input int remove_pct,
                             input bit hold);
        logic [ADDR_W-1:0] a;
        int                pick;
        write_ban_mode(ban);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        if (hold) begin
            hold_request = 1'b1;
        end
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < add_pct) begin
                a = random_filter_address();
                filter_pool.push_back(a);
                if (filter_pool.size() > POOL_DEPTH) begin
                    void'(filter_pool.pop_front());
                end
                send_request(KIND_ADD, a);
            end else if (pick < add_pct + remove_pct) begin
                a = ($urandom_range(99) < 85) ? pooled_filter() : random_filter_address();
                send_request(KIND_REMOVE, a);
            end else begin
                send_request(($urandom_range(19) == 0) ? KIND_SPARE : KIND_CHECK,
                             probe_address());
            end
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_ADD;
        address   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        write_ban_mode(1'b1);
        send_request(KIND_CHECK,  32'h0000_0000);
        send_request(KIND_CHECK,  ALL_ONES);
        send_request(KIND_SPARE,  32'h8000_0001);
        send_request(KIND_REMOVE, 32'h0102_0304);
        send_request(KIND_ADD,    32'h0000_0000);
        send_request(KIND_CHECK,  32'ha5a5_a5a5);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_ADD,    ALL_ONES);
        send_request(KIND_ADD,    32'h0a00_0001);
        send_request(KIND_ADD,    32'hc0a8_0000);
        send_request(KIND_ADD,    ALL_ONES);
        send_request(KIND_CHECK,  32'hc0a8_0507);
        send_request(KIND_CHECK,  32'hc0a9_0507);
        send_request(KIND_CHECK,  32'h0a7f_7f01);
        send_request(KIND_REMOVE, 32'h0a00_0001);
        send_request(KIND_CHECK,  ALL_ONES);
        send_request(KIND_SPARE,  32'h55aa_55aa);
        write_ban_mode(1'b0);
        send_request(KIND_CHECK,  32'hc0a8_ffff);
        send_request(KIND_CHECK,  32'h7f00_0001);
        send_request(KIND_ADD,    32'h00ff_0000);
        send_request(KIND_CHECK,  32'h12ff_3456);
        send_request(KIND_REMOVE, 32'hc0a8_0000);
        send_request(KIND_REMOVE, 32'hc0a8_0000);
        send_request(KIND_SPARE,  32'h0000_0000);

        run_phase(1'b1,  0,  0, 120, 90,  5, 1'b0);
        run_phase(1'b0, 73,  0, 260, 30, 30, 1'b0);
        run_phase(1'b1,  0, 73, 260, 15, 55, 1'b0);
        run_phase(1'b0, 33, 33, 260, 45, 25, 1'b0);
        run_phase(1'b1,  0,  0, 260, 50, 20, 1'b1);
        run_phase(1'b0, 33, 33, 260, 35, 35, 1'b0);
        run_phase(1'b1,  0, 73, 260, 40, 30, 1'b0);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
